[hdl/dic_pkg.sv]
`default_nettype none
package dic_pkg;
	localparam int AddrW = 32;
	localparam int IdW = 32;
	localparam int LifeW = 32;
	localparam int TimeW = 48;
	localparam int CountW = 7;
	localparam logic [CountW-1:0] CountMax = 7'd127;
	localparam logic [TimeW-1:0] TimeMax = {TimeW{1'b1}};

	typedef enum logic {
		REQ_LOOKUP = 1'b0,
		REQ_INSERT = 1'b1
	} req_t;

	// one classified request as it travels from front to back
	typedef struct packed {
		req_t              kind;
		logic [AddrW-1:0]  addr;
		logic [IdW-1:0]    id;
		logic [TimeW-1:0]  now;
		logic [TimeW-1:0]  expiry;
	} cmd_t;

	// one result item
	typedef struct packed {
		logic              hit;
		logic [CountW-1:0] live_count;
		logic              overflow;
	} res_t;
endpackage
`default_nettype wire

[hdl/dic_front.sv]
`default_nettype none
module dic_front (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              push,
	output logic             full,
	input  wire              req_type,
	input  wire [31:0]       source_addr,
	input  wire [31:0]       request_id,
	input  wire [31:0]       lifetime,
	input  wire [47:0]       now_time,
	output dic_pkg::cmd_t    cmd,
	output logic             cmd_valid,
	input  wire              cmd_take
);
	import dic_pkg::*;

	logic [TimeW:0] sum;
	logic           take_in;

	// compute the saturated expiry while classifying the request
	assign sum     = {1'b0, now_time} + {{(TimeW+1-LifeW){1'b0}}, lifetime};
	assign full    = cmd_valid && !cmd_take;
	assign take_in = push && !full;

	// hold one command for the back part
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
		end else if (take_in) begin
			cmd_valid <= 1'b1;
		end else if (cmd_take) begin
			cmd_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd.kind   <= req_t'(req_type);
			cmd.addr   <= source_addr;
			cmd.id     <= request_id;
			cmd.now    <= now_time;
			cmd.expiry <= sum[TimeW] ? TimeMax : sum[TimeW-1:0];
		end
	end
endmodule
`default_nettype wire

[hdl/dic_back.sv]
`default_nettype none
module dic_back #(
	parameter int DEPTH = 64
) (
	input  wire              clk,
	input  wire              arst_n,
	input  dic_pkg::cmd_t    cmd,
	input  wire              cmd_valid,
	output logic             cmd_take,
	output dic_pkg::res_t    res,
	output logic             res_valid,
	input  wire              res_take
);
	import dic_pkg::*;

	localparam int IdxW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_SCAN,
		ST_DONE
	} state_t;

	state_t               state_q;
	cmd_t                 cmd_q;
	logic [DEPTH-1:0]     valid_q;
	logic [AddrW-1:0]     mem_addr [DEPTH];
	logic [IdW-1:0]       mem_id   [DEPTH];
	logic [TimeW-1:0]     mem_exp  [DEPTH];
	logic [AddrW-1:0]     rd_addr_q;
	logic [IdW-1:0]       rd_id_q;
	logic [TimeW-1:0]     rd_exp_q;
	logic [IdxW-1:0]      rd_idx_q;
	logic [IdxW-1:0]      chk_idx_q;
	logic [IdxW-1:0]      free_idx_q;
	logic                 free_ok_q;
	logic                 hit_q;
	logic [CntW-1:0]      count_q;
	logic                 last_rd_q;
	logic                 live;
	logic                 wr_en;
	logic [CntW-1:0]      final_cnt;

	assign live     = valid_q[chk_idx_q] && !(rd_exp_q < cmd_q.now);
	assign cmd_take = (state_q == ST_IDLE) && cmd_valid && !res_valid;
	assign wr_en    = (state_q == ST_DONE) && (cmd_q.kind == REQ_INSERT) && !hit_q && free_ok_q;
	assign final_cnt = count_q + CntW'(wr_en);

	// read the table one entry a cycle; the read data is registered
	always_ff @(posedge clk) begin
		rd_addr_q <= mem_addr[rd_idx_q];
		rd_id_q   <= mem_id[rd_idx_q];
		rd_exp_q  <= mem_exp[rd_idx_q];
		if (wr_en) begin
			mem_addr[free_idx_q] <= cmd_q.addr;
			mem_id[free_idx_q]   <= cmd_q.id;
			mem_exp[free_idx_q]  <= cmd_q.expiry;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_take) begin
			cmd_q <= cmd;
		end
	end

	// sequence the purge, match, free-slot search and insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			valid_q    <= '0;
			res_valid  <= 1'b0;
			res        <= '0;
			rd_idx_q   <= '0;
			chk_idx_q  <= '0;
			free_idx_q <= '0;
			free_ok_q  <= 1'b0;
			hit_q      <= 1'b0;
			count_q    <= '0;
			last_rd_q  <= 1'b0;
		end else begin
			if (res_take) begin
				res_valid <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (cmd_take) begin
						rd_idx_q  <= '0;
						hit_q     <= 1'b0;
						free_ok_q <= 1'b0;
						count_q   <= '0;
						state_q   <= ST_READ;
					end
				end
				ST_READ: begin
					// first read is in flight
					chk_idx_q <= rd_idx_q;
					last_rd_q <= (rd_idx_q == IdxW'(DEPTH - 1));
					rd_idx_q  <= rd_idx_q + 1'b1;
					state_q   <= ST_SCAN;
				end
				ST_SCAN: begin
					if (live) begin
						count_q <= count_q + 1'b1;
						if (rd_addr_q == cmd_q.addr && rd_id_q == cmd_q.id) begin
							hit_q <= 1'b1;
						end
					end else begin
						valid_q[chk_idx_q] <= 1'b0;
						if (!free_ok_q) begin
							free_ok_q  <= 1'b1;
							free_idx_q <= chk_idx_q;
						end
					end
					if (last_rd_q) begin
						state_q <= ST_DONE;
					end else begin
						chk_idx_q <= rd_idx_q;
						last_rd_q <= (rd_idx_q == IdxW'(DEPTH - 1));
						rd_idx_q  <= rd_idx_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (wr_en) begin
						valid_q[free_idx_q] <= 1'b1;
					end
					res.hit        <= hit_q;
					res.overflow   <= (cmd_q.kind == REQ_INSERT) && !hit_q && !free_ok_q;
					res.live_count <= (final_cnt > CntW'(CountMax)) ? CountMax
						: CountW'(final_cnt);
					res_valid      <= 1'b1;
					state_q        <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

[hdl/duplicate_id_cache_with_expiry_unit.sv]
`default_nettype none
// Channel  | Handshake   | Payload
// request  | push / full | req_type, source_addr, request_id, lifetime, now_time
// result   | empty / pop | hit, live_count, overflow
//
// Each item takes one scan of the table memory in the back part, one entry per
// cycle through its single read port, then a write.
// The front register takes the next item while the back part scans.
// Reset clears all valid bits at once; no clearing pass is needed.
// A waiting result stalls the next scan, and the front register once it holds an item.
module duplicate_id_cache_with_expiry_unit #(
	parameter int DEPTH = 64
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        push,
	output logic       full,
	input  wire        req_type,
	input  wire [31:0] source_addr,
	input  wire [31:0] request_id,
	input  wire [31:0] lifetime,
	input  wire [47:0] now_time,
	output logic       empty,
	input  wire        pop,
	output logic       hit,
	output logic [6:0] live_count,
	output logic       overflow
);
	import dic_pkg::*;

	cmd_t cmd;
	res_t res;
	logic cmd_valid, cmd_take, res_valid, res_take;

	assign empty      = !res_valid;
	assign res_take   = pop && res_valid;
	assign hit        = res.hit;
	assign live_count = res.live_count;
	assign overflow   = res.overflow;

	dic_front u_front (
		.clk, .arst_n, .push, .full, .req_type, .source_addr, .request_id,
		.lifetime, .now_time, .cmd, .cmd_valid, .cmd_take
	);

	dic_back #(.DEPTH(DEPTH)) u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_take, .res, .res_valid, .res_take
	);

	// a result never reports both a hit and a dropped insert
	a_hit_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(res.hit && res.overflow)) else $error("hit with overflow");
	// a waiting result holds until transferred
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !pop) |=> (res_valid && $stable(res))) else $error("result lost");
	// back part only takes a command when one is waiting
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_take |-> cmd_valid) else $error("take without command");
endmodule
`default_nettype wire
